>>> src/rlcg_pkg.sv
// ----------------------------------------------------------------------------
// rlcg_pkg
// Types and constants shared by the lattice chain grower.
// ----------------------------------------------------------------------------
`default_nettype none
package rlcg_pkg;
  localparam int GRID_SIZE = 64;
  localparam int MAX_LENGTH = 1024;
  localparam int CW = $clog2(GRID_SIZE);
  localparam int AW = 2 * CW;
  localparam int LW = 11;
  localparam int CFG_AW = 5;

  localparam logic [2:0] REG_LENGTH = 3'd0;
  localparam logic [2:0] REG_W1 = 3'd1;
  localparam logic [2:0] REG_W2 = 3'd2;
  localparam logic [2:0] REG_W3 = 3'd3;
  localparam logic [2:0] REG_W4 = 3'd4;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_GROW = 1'b1;

  localparam logic [1:0] ST_PLACED = 2'd0;
  localparam logic [1:0] ST_TRAPPED = 2'd1;
  localparam logic [1:0] ST_IDLE = 2'd2;

  localparam logic [23:0] WEIGHT_ONE = 24'd65536;

  typedef struct packed {
    logic req_type;
    logic [15:0] random_fraction;
  } in_item_t;

  typedef struct packed {
    logic [5:0] pos_x;
    logic [5:0] pos_y;
    logic [1:0] status;
    logic [31:0] weight_mantissa;
    logic signed [15:0] weight_exponent;
    logic last;
  } out_item_t;
endpackage
`default_nettype wire

>>> src/rosenbluth_lattice_chain_grower.sv
// ----------------------------------------------------------------------------
// rosenbluth_lattice_chain_grower
// Grows a self-avoiding chain on a square grid with weighted choices.
// ----------------------------------------------------------------------------
// Grow request: 13 grid reads of the single port memory, a wait for the last
// read to land, sum, pick, two-half multiply, normalize, one write, result.
// A trapped grow ends after pick with a trapped result; a grow with no chain
// answers from idle with an idle result. Start request: a clear sweep of all
// GRID_SIZE*GRID_SIZE sites, then the write of the first site and its result.
// One request at a time; the next is taken once the result is accepted.
// Reset: control state cleared, registers to defaults; the grid is cleared
// by the clear sweep of every start request, so no pass after reset.
`default_nettype none
module rosenbluth_lattice_chain_grower (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire rlcg_pkg::in_item_t in_data,
  output logic out_valid,
  input  wire logic out_stall,
  output rlcg_pkg::out_item_t out_data,
  input  wire logic cfg_psel,
  input  wire logic cfg_penable,
  input  wire logic cfg_pwrite,
  input  wire logic [rlcg_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic cfg_pready
);
  import rlcg_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0, S_CLEAR = 4'd1, S_READ = 4'd2,
    S_SUM = 4'd3, S_PICK = 4'd4, S_MUL = 4'd5, S_NORM = 4'd6,
    S_WRITE = 4'd7, S_OUT = 4'd8, S_MULB = 4'd9;

  // configuration registers
  logic [LW-1:0] len_r;
  logic [23:0] w_r [1:4];
  logic [2:0] ridx;
  assign ridx = cfg_paddr[4:2];
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LW'(16);
      for (int i = 1; i <= 4; i++) w_r[i] <= WEIGHT_ONE;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (ridx)
        REG_LENGTH: len_r <= cfg_pwdata[LW-1:0];
        REG_W1: w_r[1] <= cfg_pwdata[23:0];
        REG_W2: w_r[2] <= cfg_pwdata[23:0];
        REG_W3: w_r[3] <= cfg_pwdata[23:0];
        REG_W4: w_r[4] <= cfg_pwdata[23:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (ridx)
      REG_LENGTH: cfg_prdata = 32'(len_r);
      REG_W1: cfg_prdata = 32'(w_r[1]);
      REG_W2: cfg_prdata = 32'(w_r[2]);
      REG_W3: cfg_prdata = 32'(w_r[3]);
      REG_W4: cfg_prdata = 32'(w_r[4]);
      default: cfg_prdata = '0;
    endcase
  end

  // effective length clamp
  logic [LW-1:0] eff_len;
  always_comb begin
    eff_len = len_r;
    if (len_r == '0) eff_len = LW'(1);
    if (32'(len_r) > MAX_LENGTH) eff_len = LW'(MAX_LENGTH);
  end

  // occupancy memory, one port
  logic grid_mem [GRID_SIZE*GRID_SIZE];
  logic [AW-1:0] mem_addr;
  logic mem_we, mem_wd, mem_rd_r;
  always_ff @(posedge clk) begin
    if (mem_we) grid_mem[mem_addr] <= mem_wd;
    mem_rd_r <= grid_mem[mem_addr];
  end

  logic [3:0] state_r;
  logic [AW-1:0] clr_r;
  logic [3:0] rc_r;          // read sequence counter, 0..12
  logic rv_r;                // read data valid in this cycle
  logic [3:0] rcl_r;         // index of the read whose data returns
  logic [12:0] occ_r;        // occupied flags per read slot
  logic [12:0] inb_r;        // in-bounds flags per read slot
  logic [CW-1:0] cx_r, cy_r;
  logic [LW-1:0] placed_r;
  logic active_r;
  logic [31:0] mant_r;
  logic signed [15:0] expo_r;
  logic [15:0] frac_r;
  logic [25:0] cw_r [4];
  logic [3:0] cand_r;
  logic [25:0] total_r;
  logic [1:0] pick_r;
  logic [63:0] prod_r;
  logic [41:0] plo_r, phi_r;
  out_item_t out_r;
  logic ov_r;

  // read slot offsets: the four neighbors of the current site, then the sites next to those
  function automatic logic signed [2:0] slot_dx(input logic [3:0] s);
    case (s)
      4'd0: slot_dx = 3'sd1;  4'd1: slot_dx = -3'sd1;
      4'd2: slot_dx = 3'sd0;  4'd3: slot_dx = 3'sd0;
      4'd4: slot_dx = 3'sd2;  4'd5: slot_dx = 3'sd1;  4'd6: slot_dx = 3'sd1;
      4'd7: slot_dx = -3'sd2; 4'd8: slot_dx = -3'sd1; 4'd9: slot_dx = -3'sd1;
      4'd10: slot_dx = 3'sd0; 4'd11: slot_dx = 3'sd0; 4'd12: slot_dx = 3'sd0;
      default: slot_dx = 3'sd0;
    endcase
  endfunction
  function automatic logic signed [2:0] slot_dy(input logic [3:0] s);
    case (s)
      4'd0: slot_dy = 3'sd0;  4'd1: slot_dy = 3'sd0;
      4'd2: slot_dy = 3'sd1;  4'd3: slot_dy = -3'sd1;
      4'd4: slot_dy = 3'sd0;  4'd5: slot_dy = 3'sd1;  4'd6: slot_dy = -3'sd1;
      4'd7: slot_dy = 3'sd0;  4'd8: slot_dy = 3'sd1;  4'd9: slot_dy = -3'sd1;
      4'd10: slot_dy = 3'sd2; 4'd11: slot_dy = 3'sd0; 4'd12: slot_dy = -3'sd2;
      default: slot_dy = 3'sd0;
    endcase
  endfunction

  logic signed [CW+2:0] sx, sy;
  logic s_inb;
  always_comb begin
    sx = $signed({3'b000, cx_r}) + (CW+3)'(slot_dx(rc_r));
    sy = $signed({3'b000, cy_r}) + (CW+3)'(slot_dy(rc_r));
    s_inb = (sx >= 0) && (sy >= 0) && (sx < GRID_SIZE) && (sy < GRID_SIZE);
  end

  // candidate weights; slot 0 of each neighbor is the current site (occupied)
  // +x: cur, 4,5,6 ; -x: cur, 7,8,9 ; +y: cur, 5,8,10 ; -y: cur, 6,9,12
  function automatic logic [2:0] cnt4(input logic a, b, c);
    cnt4 = 3'd1 + 3'(a) + 3'(b) + 3'(c);
  endfunction
  logic [2:0] ncnt [4];
  logic [12:0] tk;
  always_comb begin
    tk = occ_r & inb_r;
    ncnt[0] = cnt4(tk[4], tk[5], tk[6]);
    ncnt[1] = cnt4(tk[7], tk[8], tk[9]);
    ncnt[2] = cnt4(tk[5], tk[8], tk[10]);
    ncnt[3] = cnt4(tk[6], tk[9], tk[12]);
  end

  // pick: first candidate k with frac*total <= (cum<<16), else the last candidate
  logic [41:0] lhs;
  logic [41:0] cum [4];
  logic [1:0] pk, lastc;
  always_comb begin
    lhs = 42'(frac_r) * 42'(total_r);
    cum[0] = 42'(cw_r[0]);
    for (int i = 1; i < 4; i++) cum[i] = cum[i-1] + 42'(cw_r[i]);
    lastc = 2'd0;
    for (int i = 0; i < 4; i++) if (cand_r[i]) lastc = 2'(i);
    pk = lastc;
    for (int i = 3; i >= 0; i--)
      if (cand_r[i] && (lhs <= (cum[i] << 16))) pk = 2'(i);
  end

  // normalize
  logic [5:0] hb;
  logic [63:0] nm;
  logic signed [17:0] ne;
  always_comb begin
    hb = '0;
    for (int i = 0; i < 64; i++) if (prod_r[i]) hb = 6'(i);
    nm = (hb >= 6'd31) ? (prod_r >> (hb - 6'd31)) : (prod_r << (6'd31 - hb));
    ne = 18'(expo_r) + 18'(hb) - 18'sd47;
  end

  logic [CW-1:0] px, py;
  always_comb begin
    px = cx_r; py = cy_r;
    case (pick_r)
      2'd0: px = cx_r + CW'(1);
      2'd1: px = cx_r - CW'(1);
      2'd2: py = cy_r + CW'(1);
      default: py = cy_r - CW'(1);
    endcase
  end

  logic in_acc, out_acc;
  assign in_stall = (state_r != S_IDLE) || ov_r;
  assign in_acc = in_valid && !in_stall;
  assign out_acc = ov_r && !out_stall;
  assign out_valid = ov_r;
  assign out_data = out_r;

  always_comb begin
    mem_we = 1'b0; mem_wd = 1'b0;
    mem_addr = {sy[CW-1:0], sx[CW-1:0]};
    case (state_r)
      S_CLEAR: begin mem_we = 1'b1; mem_addr = clr_r; end
      S_WRITE: begin
        mem_we = 1'b1; mem_wd = 1'b1; mem_addr = {cy_r, cx_r};
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ov_r <= 1'b0; active_r <= 1'b0;
      placed_r <= '0; cx_r <= '0; cy_r <= '0;
      mant_r <= 32'h8000_0000; expo_r <= '0; rv_r <= 1'b0;
      clr_r <= '0; rc_r <= '0; rcl_r <= '0;
    end else begin
      if (out_acc) ov_r <= 1'b0;
      rv_r <= (state_r == S_READ);
      case (state_r)
        S_IDLE: if (in_acc) begin
          frac_r <= in_data.random_fraction;
          if (in_data.req_type == REQ_START) begin
            clr_r <= '0; state_r <= S_CLEAR;
          end else if (!active_r) begin
            out_r <= '{6'd0, 6'd0, ST_IDLE, 32'd0, 16'sd0, 1'b0};
            ov_r <= 1'b1;
          end else begin
            rc_r <= '0; state_r <= S_READ;
          end
        end
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == '1) begin
            cx_r <= CW'(GRID_SIZE/2); cy_r <= CW'(GRID_SIZE/2);
            placed_r <= LW'(1);
            mant_r <= 32'h8000_0000; expo_r <= '0;
            state_r <= S_WRITE;
          end
        end
        S_READ: begin
          inb_r[rc_r] <= s_inb;
          rcl_r <= rc_r;
          if (rc_r == 4'd12) state_r <= S_SUM;
          else rc_r <= rc_r + 4'd1;
        end
        // wait for the last read to land
        S_SUM: if (!rv_r) begin
          for (int i = 0; i < 4; i++) begin
            cand_r[i] <= inb_r[i] && !occ_r[i];
            cw_r[i] <= (inb_r[i] && !occ_r[i]) ? 26'(ncnt[i] == 3'd0 ? WEIGHT_ONE
                       : w_r[ncnt[i]]) : 26'd0;
          end
          state_r <= S_PICK;
        end
        S_PICK: begin
          total_r <= cw_r[0] + cw_r[1] + cw_r[2] + cw_r[3];
          if (cand_r == 4'd0) begin
            active_r <= 1'b0; mant_r <= '0; expo_r <= '0;
            out_r <= '{cx_r, cy_r, ST_TRAPPED, 32'd0, 16'sd0, 1'b1};
            ov_r <= 1'b1; state_r <= S_IDLE;
          end else state_r <= S_MUL;
        end
        S_MUL: begin
          pick_r <= pk;
          plo_r <= 42'(mant_r[15:0]) * 42'(total_r);
          phi_r <= 42'(mant_r[31:16]) * 42'(total_r);
          state_r <= S_MULB;
        end
        S_MULB: begin
          prod_r <= 64'(plo_r) + (64'(phi_r) << 16);
          cx_r <= px; cy_r <= py;
          placed_r <= placed_r + LW'(1);
          state_r <= S_NORM;
        end
        S_NORM: begin
          if (prod_r == '0) begin
            mant_r <= '0; expo_r <= '0;
          end else begin
            mant_r <= nm[31:0];
            expo_r <= (ne > 18'sd32767) ? 16'sd32767 :
                      (ne < -18'sd32768) ? -16'sd32768 : ne[15:0];
          end
          state_r <= S_WRITE;
        end
        S_WRITE: state_r <= S_OUT;
        S_OUT: begin
          active_r <= placed_r < eff_len;
          out_r <= '{cx_r, cy_r, ST_PLACED, mant_r, expo_r, !(placed_r < eff_len)};
          ov_r <= 1'b1; state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
      if (rv_r) occ_r[rcl_r] <= mem_rd_r;
    end
  end

  // checks
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_acc) else $error("request taken while busy");
  a_norm: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_r.status == ST_PLACED) |-> (out_r.weight_mantissa[31] ||
     out_r.weight_mantissa == 32'd0)) else $error("mantissa not normalized");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_stall) |=> ov_r && $stable(out_r)) else $error("result lost");
endmodule
`default_nettype wire
